// ----- hw/rtl/qalu_pkg.sv -----
package qalu_pkg;

    typedef enum logic [2:0] {
        OP_MUL       = 3'd0,
        OP_ADD       = 3'd1,
        OP_CONJ      = 3'd2,
        OP_NORM_SQ   = 3'd3,
        OP_NORMALIZE = 3'd4
    } op_t;

    localparam int OP_BITS = 3;
    localparam int NSQ_BITS = 32;

endpackage

// ----- hw/rtl/quaternion_alu.sv -----
// Pipelined quaternion unit: multiply, add, conjugate, squared norm, normalize.
// Stages: input, products, sums, a square-root chain and a divide chain, then the output
// register; each chain stage yields one square-root digit or one quotient bit.
// Throughput: one request per cycle; a stall at the output freezes the whole pipe.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module quaternion_alu #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [8*COMPONENT_BITS-1:0]       s_axis_tdata,
    // opcode
    input  logic [qalu_pkg::OP_BITS-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // r_w, r_x, r_y, r_z, norm_squared, zero padding
    output logic [((4*COMPONENT_BITS+qalu_pkg::NSQ_BITS+7)/8)*8-1:0] m_axis_tdata,
    // zero_norm
    output logic                              m_axis_tuser
);

    localparam int CW   = COMPONENT_BITS;
    localparam int FW   = FRACTION_BITS;
    localparam int PW   = 2 * CW;
    localparam int TW   = 2 * CW + 1;
    localparam int RW   = CW + 1;
    localparam int QW   = FW + 2;
    localparam int NW   = CW + FW + 1;
    localparam int XW   = (NW > RW + QW) ? NW : RW + QW;
    localparam int WIDE = (2 * CW + 3 > QW + 2) ? 2 * CW + 3 : QW + 2;
    localparam int NST  = RW + QW;
    localparam int NS   = 2 * CW - 31;
    localparam int NSH  = (NS > 0) ? NS : 0;
    localparam int OW   = ((4 * CW + qalu_pkg::NSQ_BITS + 7) / 8) * 8;

    localparam logic signed [WIDE-1:0] CMAXW = (WIDE'(1) <<< (CW - 1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] CMINW = -CMAXW - WIDE'(1);
    localparam logic signed [WIDE-1:0] RHALF = WIDE'(1) <<< (FW - 1);
    localparam logic signed [WIDE-1:0] QLIM  = WIDE'(1) <<< CW;

    typedef struct packed {
        logic [qalu_pkg::OP_BITS-1:0]   op;
        logic [3:0][CW-1:0]             ac;
        logic [3:0][CW-1:0]             rr;
        logic [qalu_pkg::NSQ_BITS-1:0]  nsq;
        logic                           zero;
        logic [TW-1:0]                  rem;
        logic [RW-1:0]                  root;
        logic [3:0][XW-1:0]             num;
        logic [3:0][QW-1:0]             q;
    } ch_t;

    function automatic logic [CW-1:0] sat(input logic signed [WIDE-1:0] v);
        logic [CW-1:0] r;
        if (v > CMAXW)
            r = CMAXW[CW-1:0];
        else if (v < CMINW)
            r = CMINW[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    logic en;

    // stage A: input registers
    logic                         va_reg;
    logic [qalu_pkg::OP_BITS-1:0] opa_reg;
    logic [CW-1:0]                a_reg [4];
    logic [CW-1:0]                b_reg [4];

    // stage B: products
    logic                         vb_reg;
    logic [qalu_pkg::OP_BITS-1:0] opb_reg;
    logic [CW-1:0]                ab_reg [4];
    logic [CW-1:0]                bb_reg [4];
    logic signed [PW-1:0]         pm_reg [16];
    logic [PW-1:0]                sq_reg [4];

    // stage C: sums, simple results
    logic                         vc_reg;
    ch_t                          c_reg;
    ch_t                          c_next;

    // square root and divide chain
    logic [NST-1:0]               vch_reg;
    ch_t                          ch_reg [NST];

    // output register
    logic                         vo_reg;
    logic [3:0][CW-1:0]           ro_reg;
    logic [3:0][CW-1:0]           ro_next;
    logic [qalu_pkg::NSQ_BITS-1:0] nsqo_reg;
    logic                         zo_reg;

    assign en = !vo_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vch_reg <= '0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            va_reg  <= s_axis_tvalid;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            vch_reg <= {vch_reg[NST-2:0], vc_reg};
            vo_reg  <= vch_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opa_reg <= s_axis_tuser;
            for (int i = 0; i < 4; i++)
            begin
                a_reg[i] <= s_axis_tdata[i*CW +: CW];
                b_reg[i] <= s_axis_tdata[(4+i)*CW +: CW];
            end
            opb_reg <= opa_reg;
            for (int i = 0; i < 4; i++)
            begin
                ab_reg[i] <= a_reg[i];
                bb_reg[i] <= b_reg[i];
                sq_reg[i] <= PW'($signed(a_reg[i])) * PW'($signed(a_reg[i]));
                for (int j = 0; j < 4; j++)
                    pm_reg[4*i+j] <= PW'($signed(a_reg[i])) * PW'($signed(b_reg[j]));
            end
            c_reg    <= c_next;
            ro_reg   <= ro_next;
            nsqo_reg <= ch_reg[NST-1].nsq;
            zo_reg   <= ch_reg[NST-1].zero;
        end
    end

    // stage C: Hamilton product sums, add, conjugate, squared norm
    logic signed [WIDE-1:0]   dsum [4];
    logic signed [WIDE-1:0]   drnd [4];
    logic [TW-1:0]            total;
    logic [TW+31:0]           tot_sh;

    always_comb
    begin
        dsum[0] = WIDE'(pm_reg[0])  - WIDE'(pm_reg[5])  - WIDE'(pm_reg[10]) - WIDE'(pm_reg[15]);
        dsum[1] = WIDE'(pm_reg[1])  + WIDE'(pm_reg[4])  + WIDE'(pm_reg[11]) - WIDE'(pm_reg[14]);
        dsum[2] = WIDE'(pm_reg[2])  - WIDE'(pm_reg[7])  + WIDE'(pm_reg[8])  + WIDE'(pm_reg[13]);
        dsum[3] = WIDE'(pm_reg[3])  + WIDE'(pm_reg[6])  - WIDE'(pm_reg[9])  + WIDE'(pm_reg[12]);
        for (int i = 0; i < 4; i++)
            drnd[i] = (dsum[i] + RHALF) >>> FW;

        total  = TW'(sq_reg[0]) + TW'(sq_reg[1]) + TW'(sq_reg[2]) + TW'(sq_reg[3]);
        tot_sh = {32'b0, total} >> NSH;

        c_next      = '0;
        c_next.op   = opb_reg;
        c_next.rem  = total;
        c_next.root = '0;
        for (int i = 0; i < 4; i++)
            c_next.ac[i] = ab_reg[i];

        case (opb_reg)
            qalu_pkg::OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                    c_next.rr[i] = sat(drnd[i]);
            end
            qalu_pkg::OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                    c_next.rr[i] = sat(WIDE'($signed(ab_reg[i])) + WIDE'($signed(bb_reg[i])));
            end
            qalu_pkg::OP_CONJ:
            begin
                c_next.rr[0] = sat(WIDE'($signed(ab_reg[0])));
                for (int i = 1; i < 4; i++)
                    c_next.rr[i] = sat(-WIDE'($signed(ab_reg[i])));
            end
            qalu_pkg::OP_NORM_SQ:
            begin
                c_next.nsq = tot_sh[qalu_pkg::NSQ_BITS-1:0];
            end
            qalu_pkg::OP_NORMALIZE:
            begin
                c_next.nsq  = tot_sh[qalu_pkg::NSQ_BITS-1:0];
                c_next.zero = (total == '0);
            end
            default:
            begin
                c_next.rr = '0;
            end
        endcase
    end

    // one root bit per stage, then one quotient bit per stage for all four lanes
    for (genvar s = 0; s < NST; s++)
    begin : g_st
        ch_t src;
        ch_t nxt;

        if (s == 0)
        begin : g_first
            assign src = c_reg;
        end
        else
        begin : g_rest
            assign src = ch_reg[s-1];
        end

        if (s < RW)
        begin : g_sqrt
            localparam int J = RW - 1 - s;
            logic [TW+1:0] cand;
            always_comb
            begin
                nxt  = src;
                cand = ((TW+2)'(src.root) << (J + 1)) + ((TW+2)'(1) << (2 * J));
                if ({2'b0, src.rem} >= cand)
                begin
                    nxt.rem  = src.rem - cand[TW-1:0];
                    nxt.root = src.root | (RW'(1) << J);
                end
            end
        end
        else
        begin : g_div
            localparam int K = QW - 1 - (s - RW);
            logic signed [CW:0] av   [4];
            logic [CW:0]        mag  [4];
            logic [XW-1:0]      n0   [4];
            logic [XW-1:0]      dvs;
            always_comb
            begin
                nxt = src;
                dvs = XW'(src.root) << K;
                for (int i = 0; i < 4; i++)
                begin
                    av[i]  = (CW+1)'($signed(src.ac[i]));
                    mag[i] = (av[i] < 0) ? -av[i] : av[i];
                    if (s == RW)
                    begin
                        n0[i]   = (XW'(mag[i]) << FW) + XW'(src.root >> 1);
                        nxt.q[i] = '0;
                    end
                    else
                        n0[i] = src.num[i];
                    nxt.num[i] = n0[i];
                    if (n0[i] >= dvs)
                    begin
                        nxt.num[i]  = n0[i] - dvs;
                        nxt.q[i][K] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ch_reg[s] <= nxt;
        end
    end

    // final sign and saturation of the normalized components
    logic signed [WIDE-1:0] qv [4];

    always_comb
    begin
        ro_next = ch_reg[NST-1].rr;
        for (int i = 0; i < 4; i++)
        begin
            qv[i] = WIDE'({1'b0, ch_reg[NST-1].q[i]});
            if (qv[i] > QLIM)
                qv[i] = QLIM;
            if (ch_reg[NST-1].ac[i][CW-1])
                qv[i] = -qv[i];
        end
        if (ch_reg[NST-1].op == qalu_pkg::OP_NORMALIZE && !ch_reg[NST-1].zero)
        begin
            for (int i = 0; i < 4; i++)
                ro_next[i] = sat(qv[i]);
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tuser  = zo_reg;
    assign m_axis_tdata  = OW'({nsqo_reg, ro_reg[3], ro_reg[2], ro_reg[1], ro_reg[0]});

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int ITEMS = 700;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN = 80;

    typedef struct {
        logic [CW-1:0] r [4];
        logic [31:0]   nsq;
        logic          zflag;
    } qres_t;

    class quat_scoreboard;
        qres_t pending_q[$];
        int errors = 0;

        static function logic [CW-1:0] clamp(longint v);
            if (v > 32767)
                return 16'h7fff;
            if (v < -32768)
                return 16'h8000;
            return v[CW-1:0];
        endfunction

        static function longint unsigned root(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        static function logic [CW-1:0] round_dot(longint s);
            return clamp((s + (64'sd1 <<< (FB - 1))) >>> FB);
        endfunction

        function void note_request(logic [2:0] op, logic [8*CW-1:0] d);
            longint a[4], b[4];
            longint unsigned tot, rt, mag, q;
            longint v;
            qres_t e;
            for (int i = 0; i < 4; i++)
            begin
                a[i] = longint'($signed(d[i*CW +: CW]));
                b[i] = longint'($signed(d[(4+i)*CW +: CW]));
            end
            for (int i = 0; i < 4; i++)
                e.r[i] = '0;
            e.nsq = '0;
            e.zflag = 1'b0;
            tot = 0;
            for (int i = 0; i < 4; i++)
                tot += longint'(a[i] * a[i]);
            case (op)
                qalu_pkg::OP_MUL:
                begin
                    e.r[0] = round_dot(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                    e.r[1] = round_dot(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                    e.r[2] = round_dot(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
                    e.r[3] = round_dot(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
                end
                qalu_pkg::OP_ADD:
                    for (int i = 0; i < 4; i++)
                        e.r[i] = clamp(a[i] + b[i]);
                qalu_pkg::OP_CONJ:
                begin
                    e.r[0] = clamp(a[0]);
                    for (int i = 1; i < 4; i++)
                        e.r[i] = clamp(-a[i]);
                end
                qalu_pkg::OP_NORM_SQ, qalu_pkg::OP_NORMALIZE:
                begin
                    // 33-bit Q5.28 sum dropped one bit to fit 32 bits
                    e.nsq = 32'(tot >> 1);
                    if (op == qalu_pkg::OP_NORMALIZE)
                    begin
                        if (tot == 0)
                            e.zflag = 1'b1;
                        else
                        begin
                            rt = root(tot);
                            for (int i = 0; i < 4; i++)
                            begin
                                mag = (a[i] < 0) ? -a[i] : a[i];
                                q = ((mag << FB) + (rt >> 1)) / rt;
                                if (q > (64'd1 << CW))
                                    q = 64'd1 << CW;
                                v = longint'(q);
                                e.r[i] = clamp(a[i] < 0 ? -v : v);
                            end
                        end
                    end
                end
                default:
                    ;
            endcase
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [95:0] d, logic zf);
            qres_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            for (int i = 0; i < 4; i++)
                if (d[i*CW +: CW] !== e.r[i])
                begin
                    $display("%0t: r[%0d] expected %h actual %h", $time, i, e.r[i],
                             d[i*CW +: CW]);
                    errors++;
                end
            if (d[95:64] !== e.nsq)
            begin
                $display("%0t: norm_squared expected %h actual %h", $time, e.nsq, d[95:64]);
                errors++;
            end
            if (zf !== e.zflag)
            begin
                $display("%0t: zero_norm expected %b actual %b", $time, e.zflag, zf);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [8*CW-1:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic m_axis_tuser;

    quat_scoreboard sb;
    int sent = 0;
    bit calm = 0;
    bit held = 0;
    int hold_left = 0;
    int cycles = 0;

    quaternion_alu dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [8*CW-1:0] d);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, d);
        sent++;
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(32)) - 16);
            3: return 16'(int'($urandom_range(32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (!held && sent >= 300)
            begin
                held = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 32);
        end
    end

    initial
    begin
        logic [8*CW-1:0] d;
        logic [2:0] op;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode on extremes, zero normalize, unused codes
        for (int o = 0; o < 8; o++)
        begin
            send_request(3'(o), {8{16'h7fff}});
            send_request(3'(o), {8{16'h8000}});
            if (o <= 4)
                send_request(3'(o), {16'h0001, 16'h8000, 16'h4000, 16'hc000,
                                     16'h0000, 16'h7fff, 16'h0001, 16'hffff});
        end
        send_request(qalu_pkg::OP_NORMALIZE, '0);
        send_request(qalu_pkg::OP_NORMALIZE,
                     {{4{16'h1234}}, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
        send_request(qalu_pkg::OP_MUL,
                     {16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000});

        for (int n = 0; n < ITEMS; n++)
        begin
            calm = (n >= 450 && n < 550);
            op = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            for (int i = 0; i < 8; i++)
                d[i*CW +: CW] = rand_comp();
            if (op == qalu_pkg::OP_NORMALIZE && $urandom_range(9) == 0)
                d[4*CW-1:0] = '0;
            send_request(op, d);
        end
        s_axis_tvalid <= 1'b0;
        calm = 0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
